// File: hdl/rme_pkg.sv
// Shared constants, operation codes and interface types of the register machine execute unit.
package rme_pkg;

    // Storage sizes.
    localparam int RAM_WORDS   = 4096;
    localparam int STACK_DEPTH = 256;
    localparam int RAM_AW      = $clog2(RAM_WORDS);
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int CLR_N       = (RAM_WORDS > STACK_DEPTH) ? RAM_WORDS : STACK_DEPTH;
    localparam int CLR_W       = $clog2(CLR_N);

    // Word constants.
    localparam logic [31:0] SIGN32  = 32'h8000_0000;
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONE = 32'hFFFF_FFFF;

    // Operation codes.
    localparam logic [5:0] K_NOP     = 6'd0;
    localparam logic [5:0] K_ADD     = 6'd1;
    localparam logic [5:0] K_SUB     = 6'd2;
    localparam logic [5:0] K_MUL     = 6'd3;
    localparam logic [5:0] K_DIV     = 6'd4;
    localparam logic [5:0] K_MOD     = 6'd5;
    localparam logic [5:0] K_POW     = 6'd6;
    localparam logic [5:0] K_LSH     = 6'd7;
    localparam logic [5:0] K_RSH     = 6'd8;
    localparam logic [5:0] K_AND     = 6'd9;
    localparam logic [5:0] K_OR      = 6'd10;
    localparam logic [5:0] K_NOT     = 6'd11;
    localparam logic [5:0] K_XOR     = 6'd12;
    localparam logic [5:0] K_BCAT    = 6'd13;
    localparam logic [5:0] K_HCAT    = 6'd14;
    localparam logic [5:0] K_JEQ     = 6'd15;
    localparam logic [5:0] K_JNE     = 6'd16;
    localparam logic [5:0] K_JLT     = 6'd17;
    localparam logic [5:0] K_JGT     = 6'd18;
    localparam logic [5:0] K_JLE     = 6'd19;
    localparam logic [5:0] K_JGE     = 6'd20;
    localparam logic [5:0] K_JNG     = 6'd21;
    localparam logic [5:0] K_JPZ     = 6'd22;
    localparam logic [5:0] K_JVS     = 6'd23;
    localparam logic [5:0] K_JVC     = 6'd24;
    localparam logic [5:0] K_JMP     = 6'd25;
    localparam logic [5:0] K_ST      = 6'd26;
    localparam logic [5:0] K_LD      = 6'd27;
    localparam logic [5:0] K_STI     = 6'd28;
    localparam logic [5:0] K_LDI     = 6'd29;
    localparam logic [5:0] K_STD     = 6'd30;
    localparam logic [5:0] K_LDD     = 6'd31;
    localparam logic [5:0] K_PUSH    = 6'd32;
    localparam logic [5:0] K_POP     = 6'd33;
    localparam logic [5:0] K_HALT    = 6'd34;
    localparam logic [5:0] K_PRELOAD = 6'd35;

    // Special register indexes.
    localparam logic [4:0] R_AR = 5'd12;
    localparam logic [4:0] R_SP = 5'd13;
    localparam logic [4:0] R_PC = 5'd15;

    // Operation of the iterative unit.
    typedef enum logic [1:0] {
        IT_DIV,
        IT_MOD,
        IT_POW
    } t_iter_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr;
        logic accept;
        logic cap_a;
        logic cap_b;
        logic exec;
        logic fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic is_iter;
        logic iter_done;
        logic out_busy;
    } t_stat;

endpackage

// File: hdl/rme_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/rme_iter.sv
// Iterative unit for signed divide, modulo and saturating power.
module rme_iter import rme_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_iter_op    i_op,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_result
);

    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic [4:0]         r_cnt;
    t_iter_op           r_op;
    logic [31:0]        r_rem;
    logic [31:0]        r_quo;
    logic [31:0]        r_dvs;
    logic               r_negq;
    logic               r_negr;
    logic               r_odd;
    logic [31:0]        r_pw;
    logic [31:0]        r_left;
    logic [31:0]        r_res;

    logic [31:0]        ua;
    logic [31:0]        ub;
    logic [32:0]        rem_sh;
    logic [32:0]        diff;
    logic               ge;
    logic signed [63:0] prod;
    logic               ovf;

    // Magnitudes, one restoring division step and one power step.
    always_comb begin
        ua     = i_a[31] ? (32'd0 - i_a) : i_a;
        ub     = i_b[31] ? (32'd0 - i_b) : i_b;
        rem_sh = {r_rem, r_quo[31]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = !diff[32];
        prod   = $signed(r_pw) * $signed(r_dvs);
        ovf    = (prod[63:31] != {33{prod[31]}});
    end

    // Sequencing: start, one step per cycle, then the sign fix-up or result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_op  <= i_op;
                r_odd <= i_b[0];
                if (i_op == IT_POW) begin
                    if (i_a == 32'd1) begin
                        r_res  <= 32'd1;
                        r_done <= 1'b1;
                    end else if (i_a == ALL_ONE) begin
                        r_res  <= i_b[0] ? ALL_ONE : 32'd1;
                        r_done <= 1'b1;
                    end else if (i_b[31]) begin
                        r_res  <= (i_a == 32'd0) ? SAT_POS : 32'd0;
                        r_done <= 1'b1;
                    end else if (i_a == 32'd0) begin
                        r_res  <= (i_b == 32'd0) ? 32'd1 : 32'd0;
                        r_done <= 1'b1;
                    end else begin
                        r_busy <= 1'b1;
                        r_pw   <= 32'd1;
                        r_dvs  <= i_a;
                        r_left <= i_b;
                    end
                end else if (i_b == 32'd0) begin
                    r_res  <= (i_op == IT_DIV) ? 32'd0 : i_a;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_rem  <= 32'd0;
                    r_quo  <= ua;
                    r_dvs  <= ub;
                    r_negq <= i_a[31] ^ i_b[31];
                    r_negr <= i_a[31];
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                if (r_op == IT_DIV) begin
                    r_res <= r_negq ? (32'd0 - r_quo) : r_quo;
                end else begin
                    r_res <= r_negr ? (32'd0 - r_rem) : r_rem;
                end
            end else if (r_busy) begin
                if (r_op == IT_POW) begin
                    if (r_left == 32'd0) begin
                        r_busy <= 1'b0;
                        r_res  <= r_pw;
                        r_done <= 1'b1;
                    end else if (ovf) begin
                        r_busy <= 1'b0;
                        r_res  <= (r_dvs[31] && r_odd) ? SIGN32 : SAT_POS;
                        r_done <= 1'b1;
                    end else begin
                        r_pw   <= prod[31:0];
                        r_left <= r_left - 32'd1;
                    end
                end else begin
                    r_rem <= ge ? diff[31:0] : rem_sh[31:0];
                    r_quo <= {r_quo[30:0], ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_busy <= 1'b0;
                        r_fin  <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// File: hdl/rme_dpath.sv
// Datapath: registers, flags, ALU, memories, stack and the result register.
module rme_dpath import rme_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [5:0]  i_kind,
    input  logic        i_set_flags,
    input  logic        i_use_immediate,
    input  logic [4:0]  i_dest_reg,
    input  logic [4:0]  i_src_a_reg,
    input  logic [4:0]  i_src_b_reg,
    input  logic [15:0] i_immediate,
    input  logic [31:0] i_preload_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_program_counter,
    output logic        o_zero_flag,
    output logic        o_negative_flag,
    output logic        o_overflow_flag,
    output logic [31:0] o_dest_value,
    output logic        o_dest_written,
    output logic        o_halted
);

    // Captured instruction.
    logic [5:0]  r_kind;
    logic        r_sf;
    logic        r_imm;
    logic [4:0]  r_rd;
    logic [4:0]  r_ra;
    logic [4:0]  r_rb;
    logic [15:0] r_imm16;
    logic [31:0] r_pword;

    // Architectural state kept in flip-flops.
    logic [31:0] r_ar;
    logic [31:0] r_sp;
    logic [31:0] r_pc;
    logic        r_z;
    logic        r_n;
    logic        r_v;
    logic [15:0] r_rf_vld;
    logic [CLR_W-1:0] r_clr_cnt;

    // Working registers.
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_res;
    logic        r_mem_ok;
    logic        r_stk_ok;

    // Result register.
    logic        r_ovalid;
    logic [31:0] r_opc;
    logic        r_oz;
    logic        r_on;
    logic        r_ov;
    logic [31:0] r_odval;
    logic        r_odwr;
    logic        r_ohalt;

    logic [4:0]  sel_idx;
    logic [31:0] sel_val;
    logic [31:0] rf_dout;
    logic [15:0] op16;
    logic [31:0] alu;
    logic [31:0] sp_m1;
    logic        is_alu;
    logic        is_ld;
    logic        is_st;
    logic        is_iter;
    logic        take;
    logic [31:0] wv;
    logic        wen;
    logic        rf_we;
    logic [31:0] ar_mid;
    logic [31:0] sp_mid;
    logic [31:0] pc_mid;
    logic [31:0] n_ar;
    logic [31:0] n_sp;
    logic [31:0] n_pc;
    logic        n_z;
    logic        n_n;
    logic        n_v;
    logic        it_done;
    logic [31:0] it_res;
    t_iter_op    it_op;

    logic              dm_we;
    logic [RAM_AW-1:0] dm_waddr;
    logic [31:0]       dm_wdata;
    logic              dm_re;
    logic [31:0]       dm_dout;
    logic              st_we;
    logic [STK_AW-1:0] st_waddr;
    logic [15:0]       st_wdata;
    logic              st_re;
    logic [15:0]       st_dout;

    // Operation classes.
    always_comb begin
        is_alu  = (r_kind inside {[K_ADD:K_HCAT]});
        is_ld   = (r_kind inside {K_LD, K_LDI, K_LDD});
        is_st   = (r_kind inside {K_ST, K_STI, K_STD});
        is_iter = (r_kind inside {K_DIV, K_MOD, K_POW});
        case (r_kind)
            K_DIV:   it_op = IT_DIV;
            K_MOD:   it_op = IT_MOD;
            default: it_op = IT_POW;
        endcase
    end

    // Operand read: special registers from flip-flops, the rest from the register RAM.
    always_comb begin
        sel_idx = i_cmd.cap_a ? r_ra : r_rb;
        if (sel_idx[4]) begin
            sel_val = 32'd0;
        end else begin
            case (sel_idx)
                R_AR:    sel_val = r_ar;
                R_SP:    sel_val = r_sp;
                R_PC:    sel_val = r_pc;
                default: sel_val = r_rf_vld[sel_idx[3:0]] ? rf_dout : 32'd0;
            endcase
        end
        op16  = r_imm ? r_imm16 : r_a[15:0];
        sp_m1 = r_sp - 32'd1;
    end

    // ALU for the non-iterative operations.
    always_comb begin
        case (r_kind)
            K_ADD:   alu = r_a + r_b;
            K_SUB:   alu = r_a - r_b;
            K_MUL:   alu = r_a * r_b;
            K_LSH:   alu = (r_b >= 32'd32) ? 32'd0 : (r_a << r_b[4:0]);
            K_RSH:   alu = (r_b >= 32'd32) ? {32{r_a[31]}}
                                           : 32'($signed(r_a) >>> r_b[4:0]);
            K_AND:   alu = r_a & r_b;
            K_OR:    alu = r_a | r_b;
            K_NOT:   alu = ~r_a;
            K_XOR:   alu = r_a ^ r_b;
            K_BCAT:  alu = (r_a << 8) | r_b;
            K_HCAT:  alu = (r_a << 16) | r_b;
            default: alu = 32'd0;
        endcase
    end

    // Jump condition.
    always_comb begin
        case (r_kind)
            K_JEQ:   take = r_z;
            K_JNE:   take = !r_z;
            K_JLT:   take = (r_n != r_v);
            K_JGT:   take = !r_z && (r_n == r_v);
            K_JLE:   take = r_z || (r_n != r_v);
            K_JGE:   take = (r_n == r_v);
            K_JNG:   take = r_n;
            K_JPZ:   take = !r_n;
            K_JVS:   take = r_v;
            K_JVC:   take = !r_v;
            default: take = 1'b1;
        endcase
    end

    // Memory and stack ports: clearing pass after reset, then accesses at execute.
    always_comb begin
        if (i_cmd.clr) begin
            dm_we    = (32'(r_clr_cnt) < 32'(RAM_WORDS));
            dm_waddr = r_clr_cnt[RAM_AW-1:0];
            dm_wdata = 32'd0;
            st_we    = (32'(r_clr_cnt) < 32'(STACK_DEPTH));
            st_waddr = r_clr_cnt[STK_AW-1:0];
            st_wdata = 16'd0;
        end else begin
            dm_we    = i_cmd.exec && ((is_st && (r_ar < 32'(RAM_WORDS))) ||
                       ((r_kind == K_PRELOAD) && (32'(r_imm16) < 32'(RAM_WORDS))));
            dm_waddr = (r_kind == K_PRELOAD) ? r_imm16[RAM_AW-1:0] : r_ar[RAM_AW-1:0];
            dm_wdata = (r_kind == K_PRELOAD) ? r_pword : {16'd0, op16};
            st_we    = i_cmd.exec && (r_kind == K_PUSH) && (r_sp < 32'(STACK_DEPTH));
            st_waddr = r_sp[STK_AW-1:0];
            st_wdata = op16;
        end
        dm_re = i_cmd.exec && is_ld;
        st_re = i_cmd.exec && (r_kind == K_POP);
    end

    // Write-back value and the special registers after the step.
    always_comb begin
        if (is_alu) begin
            wv = is_iter ? it_res : r_res;
        end else if (is_ld) begin
            wv = dm_dout;
        end else begin
            wv = {16'd0, st_dout};
        end
        wen = !r_rd[4] && (is_alu || (is_ld && r_mem_ok) || ((r_kind == K_POP) && r_stk_ok));
        rf_we = i_cmd.fin && wen && (r_rd != R_AR) && (r_rd != R_SP) && (r_rd != R_PC);

        ar_mid = (wen && (r_rd == R_AR)) ? wv : r_ar;
        sp_mid = (wen && (r_rd == R_SP)) ? wv : r_sp;
        pc_mid = (wen && (r_rd == R_PC)) ? wv : r_pc;

        case (r_kind)
            K_STI, K_LDI: n_ar = ar_mid + 32'd1;
            K_STD, K_LDD: n_ar = ar_mid - 32'd1;
            default:      n_ar = ar_mid;
        endcase

        case (r_kind)
            K_PUSH:  n_sp = r_sp + 32'd1;
            K_POP:   n_sp = sp_m1;
            default: n_sp = sp_mid;
        endcase

        if (r_kind inside {[K_JEQ:K_JMP]}) begin
            n_pc = take ? {16'd0, op16} : (r_pc + 32'd1);
        end else if (r_kind inside {[K_NOP:K_HCAT], [K_ST:K_POP]}) begin
            n_pc = pc_mid + 32'd1;
        end else begin
            n_pc = r_pc;
        end

        n_z = r_z;
        n_n = r_n;
        n_v = r_v;
        if (is_alu && r_sf) begin
            n_z = (wv == 32'd0);
            n_n = wv[31];
            if (r_kind == K_ADD) begin
                n_v = (~(r_a ^ r_b) & (r_a ^ wv)) >> 31 != 32'd0;
            end else if (r_kind == K_SUB) begin
                n_v = ((r_a ^ r_b) & (r_a ^ wv)) >> 31 != 32'd0;
            end
        end
    end

    // Control state: clear counter, register valid bits, architectural registers, result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_rf_vld  <= '0;
            r_ar      <= 32'd0;
            r_sp      <= 32'd0;
            r_pc      <= 32'd0;
            r_z       <= 1'b0;
            r_n       <= 1'b0;
            r_v       <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
            if (rf_we) begin
                r_rf_vld[r_rd[3:0]] <= 1'b1;
            end
            if (i_cmd.fin) begin
                r_ar     <= n_ar;
                r_sp     <= n_sp;
                r_pc     <= n_pc;
                r_z      <= n_z;
                r_n      <= n_n;
                r_v      <= n_v;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers: instruction capture, operands, execute results, output fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= i_kind;
            r_sf    <= i_set_flags;
            r_imm   <= i_use_immediate;
            r_rd    <= i_dest_reg;
            r_ra    <= i_src_a_reg;
            r_rb    <= i_src_b_reg;
            r_imm16 <= i_immediate;
            r_pword <= i_preload_word;
        end
        if (i_cmd.cap_a) begin
            r_a <= sel_val;
        end
        if (i_cmd.cap_b) begin
            r_b <= r_imm ? {{24{r_imm16[7]}}, r_imm16[7:0]} : sel_val;
        end
        if (i_cmd.exec) begin
            r_res    <= alu;
            r_mem_ok <= (r_ar < 32'(RAM_WORDS));
            r_stk_ok <= (sp_m1 < 32'(STACK_DEPTH));
        end
        if (i_cmd.fin) begin
            r_opc   <= n_pc;
            r_oz    <= n_z;
            r_on    <= n_n;
            r_ov    <= n_v;
            r_odval <= wen ? wv : 32'd0;
            r_odwr  <= wen;
            r_ohalt <= (r_kind == K_HALT);
        end
    end

    // General register file: read A at the transfer and B in the cycle after it.
    rme_ram #(.WIDTH(32), .DEPTH(16)) u_regs (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_rd[3:0]),
        .i_wdata (wv),
        .i_re    (i_cmd.accept || i_cmd.cap_a),
        .i_raddr (i_cmd.accept ? i_src_a_reg[3:0] : r_rb[3:0]),
        .o_rdata (rf_dout)
    );

    // Data memory.
    rme_ram #(.WIDTH(32), .DEPTH(RAM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (dm_re),
        .i_raddr (r_ar[RAM_AW-1:0]),
        .o_rdata (dm_dout)
    );

    // Push-down stack.
    rme_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (sp_m1[STK_AW-1:0]),
        .o_rdata (st_dout)
    );

    // Divide, modulo and power unit.
    rme_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.exec && is_iter),
        .i_op     (it_op),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_done   (it_done),
        .o_result (it_res)
    );

    // Status to the controller.
    always_comb begin
        o_stat.clr_done  = (r_clr_cnt == CLR_W'(CLR_N - 1));
        o_stat.is_iter   = is_iter;
        o_stat.iter_done = it_done;
        o_stat.out_busy  = r_ovalid && i_stall;
    end

    assign o_valid           = r_ovalid;
    assign o_program_counter = r_opc;
    assign o_zero_flag       = r_oz;
    assign o_negative_flag   = r_on;
    assign o_overflow_flag   = r_ov;
    assign o_dest_value      = r_odval;
    assign o_dest_written    = r_odwr;
    assign o_halted          = r_ohalt;

endmodule

// File: hdl/rme_ctrl.sv
// Controller state machine that sequences one instruction through the datapath.
module rme_ctrl import rme_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RDA   = 7'b0000100,
        S_RDB   = 7'b0001000,
        S_EXEC  = 7'b0010000,
        S_ITER  = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = S_RDA;
                end
            end
            S_RDA: begin
                o_cmd.cap_a = 1'b1;
                n_state     = S_RDB;
            end
            S_RDB: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.is_iter ? S_ITER : S_FIN;
            end
            S_ITER: begin
                if (i_stat.iter_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = !i_stat.out_busy;
                if (!i_stat.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // The iterative unit finishes only while the controller waits for it.
    a_iter_done_in_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.iter_done |-> (r_state == S_ITER))
        else $error("iterative unit finished outside the wait state");

    // Execute leads to either the iterative wait or the finish step.
    a_exec_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> ((r_state == S_ITER) || (r_state == S_FIN)))
        else $error("execute step not followed by wait or finish");

    // Idle is entered only after a finished instruction or the clearing pass.
    a_idle_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_IDLE) |-> ($past(o_cmd.fin) || $past(o_cmd.clr)))
        else $error("idle entered without a finish or clear");

    // A finish never overwrites a result that is still held.
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> !i_stat.out_busy)
        else $error("finish while the result register is held");
`endif

endmodule

// File: hdl/register_machine_execute_unit.sv
// Top level of the register machine execute unit: controller plus datapath.
// Sequence: the input transfer in idle, operand reads A and B, execute, a wait in the
// iterative unit for divide, modulo and power, then the finish step that loads the result
// register; the finish waits while the held result is stalled. A new input is taken only
// after the previous instruction has finished, so instructions do not overlap.
// Reset: synchronous, active low; a clearing pass zeroes the data memory and the stack,
// and no input is taken until it ends.
module register_machine_execute_unit import rme_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_kind,
    input  logic        i_set_flags,
    input  logic        i_use_immediate,
    input  logic [4:0]  i_dest_reg,
    input  logic [4:0]  i_src_a_reg,
    input  logic [4:0]  i_src_b_reg,
    input  logic [15:0] i_immediate,
    input  logic [31:0] i_preload_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_program_counter,
    output logic        o_zero_flag,
    output logic        o_negative_flag,
    output logic        o_overflow_flag,
    output logic [31:0] o_dest_value,
    output logic        o_dest_written,
    output logic        o_halted
);

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    rme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // Datapath.
    rme_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_kind            (i_kind),
        .i_set_flags       (i_set_flags),
        .i_use_immediate   (i_use_immediate),
        .i_dest_reg        (i_dest_reg),
        .i_src_a_reg       (i_src_a_reg),
        .i_src_b_reg       (i_src_b_reg),
        .i_immediate       (i_immediate),
        .i_preload_word    (i_preload_word),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_program_counter (o_program_counter),
        .o_zero_flag       (o_zero_flag),
        .o_negative_flag   (o_negative_flag),
        .o_overflow_flag   (o_overflow_flag),
        .o_dest_value      (o_dest_value),
        .o_dest_written    (o_dest_written),
        .o_halted          (o_halted)
    );

endmodule
